[hw/rtl/lpna_pkg.sv]
package lpna_pkg;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [16:0] bytes_left;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       unit_start;
		logic       run_last;
	} out_t;

	// one result descriptor handed from the parser to the output stage
	typedef struct packed {
		logic       valid;
		logic       start;
		logic [7:0] data;
	} emit_t;

	typedef enum logic [2:0] {
		PH_PREFIX  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_DROP    = 3'b100
	} phase_t;

	localparam int unsigned PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_PREFIX_BYTES = 1'b0;
	localparam logic [2:0] PREFIX_BYTES_RESET = 3'd4;
	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_LAST = 8'h01;
	// start code bytes that follow the first one
	localparam logic [1:0] SC_TAIL = 2'd3;

endpackage

[hw/rtl/lpna_regs.sv]
module lpna_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpna_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [2:0]                   prefix_bytes
);

	logic [2:0] prefix_bytes_q;
	logic       sel_prefix;

	assign sel_prefix = paddr[lpna_pkg::PADDR_W-1:2] == lpna_pkg::REG_PREFIX_BYTES;
	assign pready = 1'b1;
	assign prefix_bytes = prefix_bytes_q;
	assign prdata = sel_prefix ? {29'd0, prefix_bytes_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_bytes_q <= lpna_pkg::PREFIX_BYTES_RESET;
		end else if (psel && penable && pwrite && pready && sel_prefix) begin
			prefix_bytes_q <= pwdata[2:0];
		end
	end

endmodule

[hw/rtl/lpna_parse.sv]
module lpna_parse #(
	parameter int unsigned FRAME_BYTES_MAX = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lpna_pkg::in_t       in_data,
	input  logic [2:0]          prefix_bytes,
	input  logic                emit_ready,
	output lpna_pkg::emit_t     emit
);

	logic                 valid_s1;
	lpna_pkg::in_t        item_s1;

	lpna_pkg::phase_t     phase_q, phase_d;
	logic [1:0]           prefix_count_q, prefix_count_d;
	logic [31:0]          unit_length_q, unit_length_d;
	logic [16:0]          payload_left_q, payload_left_d;

	logic [16:0]          left;
	logic [31:0]          len_next;
	logic                 size_ok;
	logic                 emits;
	logic                 adv;
	logic                 accept;

	always_comb begin
		left = item_s1.bytes_left;
		if (32'(item_s1.bytes_left) > 32'(FRAME_BYTES_MAX)) begin
			left = 17'(FRAME_BYTES_MAX);
		end
		if (left == 17'd0) begin
			left = 17'd1;
		end

		size_ok = (prefix_bytes == 3'd1) || (prefix_bytes == 3'd2) || (prefix_bytes == 3'd4);
		len_next = {unit_length_q[23:0], item_s1.frame_byte};

		phase_d        = phase_q;
		prefix_count_d = prefix_count_q;
		unit_length_d  = unit_length_q;
		payload_left_d = payload_left_q;
		emit.valid     = 1'b0;
		emit.start     = 1'b0;
		emit.data      = item_s1.frame_byte;

		unique case (phase_q)
			lpna_pkg::PH_PREFIX: begin
				if (!size_ok || (prefix_count_q == 2'd0 && {14'd0, prefix_bytes} > left)) begin
					phase_d = lpna_pkg::PH_DROP;
				end else if ({1'b0, prefix_count_q} + 3'd1 >= prefix_bytes) begin
					// prefix complete: start code unless the unit overruns the frame
					if (len_next > {15'd0, left - 17'd1}) begin
						phase_d = lpna_pkg::PH_DROP;
					end else begin
						emit.valid     = 1'b1;
						emit.start     = 1'b1;
						payload_left_d = len_next[16:0];
						phase_d = (len_next != 32'd0) ? lpna_pkg::PH_PAYLOAD
							: lpna_pkg::PH_PREFIX;
					end
					prefix_count_d = 2'd0;
					unit_length_d  = 32'd0;
				end else begin
					unit_length_d  = len_next;
					prefix_count_d = prefix_count_q + 2'd1;
				end
			end
			lpna_pkg::PH_PAYLOAD: begin
				emit.valid = 1'b1;
				if (payload_left_q != 17'd0) begin
					payload_left_d = payload_left_q - 17'd1;
				end
				if (payload_left_d == 17'd0) begin
					phase_d = lpna_pkg::PH_PREFIX;
				end
			end
			lpna_pkg::PH_DROP: begin
			end
			default: begin
				phase_d = lpna_pkg::PH_DROP;
			end
		endcase

		// last byte of the frame: back to prefix parsing
		if (left == 17'd1) begin
			phase_d        = lpna_pkg::PH_PREFIX;
			prefix_count_d = 2'd0;
			unit_length_d  = 32'd0;
			payload_left_d = 17'd0;
		end

		emits = emit.valid;
		emit.valid = emit.valid && valid_s1;
	end

	assign adv      = valid_s1 && (!emits || emit_ready);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			phase_q        <= lpna_pkg::PH_PREFIX;
			prefix_count_q <= 2'd0;
			unit_length_q  <= 32'd0;
			payload_left_q <= 17'd0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
			if (adv) begin
				phase_q        <= phase_d;
				prefix_count_q <= prefix_count_d;
				unit_length_q  <= unit_length_d;
				payload_left_q <= payload_left_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpna_pkg::PH_PAYLOAD |-> payload_left_q != 17'd0)
		else $error("payload phase with nothing left to pass");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1) && $stable(phase_q))
		else $error("held item or state changed while waiting for output");

endmodule

[hw/rtl/lpna_ser.sv]
module lpna_ser (
	input  logic              clk,
	input  logic              arst_n,
	input  lpna_pkg::emit_t   emit,
	output logic              emit_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output lpna_pkg::out_t    out_data
);

	logic           out_valid_q;
	lpna_pkg::out_t out_q;
	logic [1:0]     sc_left_q;
	logic           taken;

	assign taken      = out_valid_q && !out_stall;
	assign emit_ready = !out_valid_q || (taken && sc_left_q == 2'd0);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sc_left_q   <= 2'd0;
		end else if (emit.valid && emit_ready) begin
			out_valid_q <= 1'b1;
			sc_left_q   <= emit.start ? lpna_pkg::SC_TAIL : 2'd0;
		end else if (taken) begin
			out_valid_q <= sc_left_q != 2'd0;
			if (sc_left_q != 2'd0) begin
				sc_left_q <= sc_left_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit_ready) begin
			out_q.out_byte   <= emit.start ? lpna_pkg::SC_ZERO : emit.data;
			out_q.unit_start <= emit.start;
			out_q.run_last   <= !emit.start;
		end else if (taken && sc_left_q != 2'd0) begin
			// advance through the start code
			out_q.out_byte   <= (sc_left_q == 2'd1) ? lpna_pkg::SC_LAST : lpna_pkg::SC_ZERO;
			out_q.unit_start <= 1'b0;
			out_q.run_last   <= sc_left_q == 2'd1;
		end
	end

	a_mid_code_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sc_left_q != 2'd0 |-> !out_q.run_last)
		else $error("beat marked last inside a start code");

	a_start_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.unit_start |-> out_q.out_byte == lpna_pkg::SC_ZERO
			&& sc_left_q == lpna_pkg::SC_TAIL)
		else $error("start code does not open with a zero byte");

	a_code_continues: assert property (@(posedge clk) disable iff (!arst_n)
		taken && sc_left_q != 2'd0 |=> out_valid_q && !out_q.unit_start)
		else $error("start code cut short");

endmodule

[hw/rtl/length_prefixed_nal_to_annexb.sv]
// Length-prefixed NAL to Annex-B byte stream converter.
// Input channel: one frame byte per beat with the count of frame bytes left,
// accepted when in_valid is high and in_stall low. Output channel: one Annex-B
// byte per beat with unit_start on the first start code byte and run_last on
// the last beat caused by an input byte.
// Prefix bytes are gathered into the unit length; a completed prefix yields the
// four start code beats 00 00 00 01, payload bytes pass one beat each, dropped
// bytes and incomplete prefix bytes yield nothing.
// A byte accepted into the input register is decoded there, and its first result
// beat is registered in the output register once that register can take it.
// Throughput: one byte per cycle for dropped bytes, and for payload bytes while
// the output is not stalled; a byte that completes a prefix occupies the output
// register for its four start code beats, serialised by the single output register.
// The input register keeps accepting while a finished beat waits at the output.
// A stall on the output holds the output beat; the parser holds its item and
// raises in_stall only when its next beat cannot enter the output register.
// Reset clears the parse state to prefix parsing and sets prefix_bytes to 4.
// prefix_bytes lies at byte address 0 of the register port.
module length_prefixed_nal_to_annexb #(
	parameter int unsigned FRAME_BYTES_MAX = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  lpna_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output lpna_pkg::out_t               out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpna_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [2:0]      prefix_bytes;
	lpna_pkg::emit_t emit;
	logic            emit_ready;

	lpna_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.prefix_bytes (prefix_bytes)
	);

	lpna_parse #(
		.FRAME_BYTES_MAX (FRAME_BYTES_MAX)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.prefix_bytes (prefix_bytes),
		.emit_ready   (emit_ready),
		.emit         (emit)
	);

	lpna_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.emit       (emit),
		.emit_ready (emit_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

[dv/lpna_annexb_checker.sv]
module lpna_annexb_checker #(
	parameter int unsigned FRAME_BYTES_MAX = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  lpna_pkg::in_t                in_data,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  lpna_pkg::out_t               out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lpna_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	input  logic                         pready,
	output int unsigned                  mismatches,
	output int unsigned                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [lpna_pkg::PADDR_W-1:0] PREFIX_BYTES_ADDR =
		{lpna_pkg::REG_PREFIX_BYTES, 2'b00};

	// shadow of the register and of the parse state
	logic [2:0]       prefix_size;
	lpna_pkg::phase_t parse_phase;
	logic [1:0]       prefix_seen;
	logic [31:0]      unit_len;
	logic [16:0]      payload_rem;

	lpna_pkg::out_t annexb_q[$];
	lpna_pkg::out_t oldest;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic restart_frame();
		parse_phase = lpna_pkg::PH_PREFIX;
		prefix_seen = '0;
		unit_len    = '0;
		payload_rem = '0;
	endtask

	// Work out the Annex-B beats that one frame byte causes and queue them.
	task automatic convert_frame_byte(input lpna_pkg::in_t item);
		logic [16:0]    left;
		lpna_pkg::out_t beats[$];
		lpna_pkg::out_t beat;
		left = item.bytes_left;
		if (32'(item.bytes_left) > 32'(FRAME_BYTES_MAX))
			left = 17'(FRAME_BYTES_MAX);
		if (left == 17'd0)
			left = 17'd1;
		beat.unit_start = 1'b0;
		beat.run_last   = 1'b0;

		case (parse_phase)
			lpna_pkg::PH_PREFIX: begin
				if (!(prefix_size inside {3'd1, 3'd2, 3'd4}) ||
						(prefix_seen == 2'd0 && left < 17'(prefix_size))) begin
					parse_phase = lpna_pkg::PH_DROP;
				end else begin
					unit_len = {unit_len[23:0], item.frame_byte};
					if (int'(prefix_seen) + 1 >= int'(prefix_size)) begin
						if (unit_len > 32'(left) - 32'd1) begin
							parse_phase = lpna_pkg::PH_DROP;
						end else begin
							beat.out_byte   = lpna_pkg::SC_ZERO;
							beat.unit_start = 1'b1;
							beats = {beats, beat};
							beat.unit_start = 1'b0;
							repeat (2) beats = {beats, beat};
							beat.out_byte = lpna_pkg::SC_LAST;
							beats = {beats, beat};
							payload_rem = unit_len[16:0];
							parse_phase = (unit_len != 0) ? lpna_pkg::PH_PAYLOAD
								: lpna_pkg::PH_PREFIX;
						end
						prefix_seen = '0;
						unit_len    = '0;
					end else begin
						prefix_seen = prefix_seen + 2'd1;
					end
				end
			end
			lpna_pkg::PH_PAYLOAD: begin
				beat.out_byte = item.frame_byte;
				beats = {beats, beat};
				if (payload_rem != 0)
					payload_rem = payload_rem - 17'd1;
				if (payload_rem == 0)
					parse_phase = lpna_pkg::PH_PREFIX;
			end
			default: begin
				// dropped bytes give nothing
			end
		endcase

		if (beats.size() != 0)
			beats[beats.size() - 1].run_last = 1'b1;
		annexb_q = {annexb_q, beats};

		if (left <= 17'd1)
			restart_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_size = lpna_pkg::PREFIX_BYTES_RESET;
			restart_frame();
			annexb_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == PREFIX_BYTES_ADDR)
				prefix_size = pwdata[2:0];
			if (in_valid && !in_stall)
				convert_frame_byte(in_data);
			if (out_valid && !out_stall) begin
				if (annexb_q.size() == 0) begin
					report_mismatch($sformatf("unexpected beat, byte %02h start %0b last %0b",
						out_data.out_byte, out_data.unit_start, out_data.run_last));
				end else begin
					oldest = annexb_q.pop_front();
					if (out_data.out_byte !== oldest.out_byte)
						report_mismatch($sformatf("out_byte %02h, want %02h",
							out_data.out_byte, oldest.out_byte));
					if (out_data.unit_start !== oldest.unit_start)
						report_mismatch($sformatf("unit_start %0b, want %0b",
							out_data.unit_start, oldest.unit_start));
					if (out_data.run_last !== oldest.run_last)
						report_mismatch($sformatf("run_last %0b, want %0b",
							out_data.run_last, oldest.run_last));
				end
			end
			pending = annexb_q.size();
		end
	end

endmodule

[dv/length_prefixed_nal_to_annexb_tb.sv]
module length_prefixed_nal_to_annexb_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_BYTES_MAX = 65536;
	localparam int unsigned CLK_PERIOD      = 12;
	localparam int unsigned QUIET_LIMIT     = 1000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned HOLD_CYCLES     = 64;
	localparam int unsigned RANDOM_ITEMS    = 80;
	localparam logic [lpna_pkg::PADDR_W-1:0] PREFIX_BYTES_ADDR =
		{lpna_pkg::REG_PREFIX_BYTES, 2'b00};

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	lpna_pkg::in_t                in_data   = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	lpna_pkg::out_t               out_data;
	logic                         psel      = 1'b0;
	logic                         penable   = 1'b0;
	logic                         pwrite    = 1'b0;
	logic [lpna_pkg::PADDR_W-1:0] paddr     = '0;
	logic [31:0]                  pwdata    = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	bit          calm         = 1'b0;
	bit          hold_req     = 1'b0;
	logic [7:0]  frame_bytes[$];

	always #(CLK_PERIOD / 2) clk = ~clk;

	length_prefixed_nal_to_annexb #(
		.FRAME_BYTES_MAX(FRAME_BYTES_MAX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lpna_annexb_checker #(
		.FRAME_BYTES_MAX(FRAME_BYTES_MAX)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 9);
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic [16:0] left);
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {b, left};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Send the gathered bytes as one frame. An open frame claims far more bytes
	// left than it carries and is closed early by a last-byte marker.
	task automatic send_frame(input bit open);
		int unsigned n;
		logic [16:0] base;
		n    = frame_bytes.size();
		base = open ? 17'($urandom_range(n + 3000, 131071)) : 17'(n);
		for (int unsigned i = 0; i < n; i++)
			send_beat(frame_bytes[i], (open && i == n - 1) ? 17'd1 : base - 17'(i));
	endtask

	task automatic send_noise(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_beat(8'($urandom()), (i == count - 1) ? 17'($urandom_range(0, 1)) :
				17'($urandom_range(0, 131071)));
	endtask

	task automatic push_prefix(input logic [2:0] p, input logic [31:0] len);
		for (int k = int'(p) - 1; k >= 0; k--)
			frame_bytes = {frame_bytes, len[8 * k +: 8]};
	endtask

	task automatic send_random_frame(input logic [2:0] p, output int unsigned n);
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		logic [31:0] big;
		frame_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick >= 90) begin
			n = $urandom_range(2, 5);
			send_noise(n);
		end else if (pick >= 75) begin
			big = $urandom_range(0, 2) == 0 ? $urandom() :
				32'($urandom_range(6, (p == 3'd1) ? 255 : 2000));
			push_prefix(p, big);
			repeat ($urandom_range(2, 4)) frame_bytes = {frame_bytes, 8'($urandom())};
			n = frame_bytes.size();
			send_frame(1'b1);
		end else begin
			repeat ($urandom_range(1, 3)) begin
				len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
				push_prefix(p, len);
				repeat (len) frame_bytes = {frame_bytes, 8'($urandom())};
			end
			// broken frames: cut short, or trailing bytes too few for a prefix
			if (pick >= 60) begin
				if (p > 3'd1 && $urandom_range(0, 1)) begin
					repeat ($urandom_range(1, int'(p) - 1))
						frame_bytes = {frame_bytes, 8'($urandom())};
				end else begin
					cut = $urandom_range(1, 3);
					while (cut > 0 && frame_bytes.size() > 1) begin
						frame_bytes.delete(frame_bytes.size() - 1);
						cut--;
					end
				end
			end
			n = frame_bytes.size();
			send_frame(1'b0);
		end
	endtask

	// Drain: dropped bytes give no beats, so allow the pipeline to empty too.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_prefix_bytes(input logic [2:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PREFIX_BYTES_ADDR;
		pwdata  <= {29'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [2:0]  plan[8];
		logic [2:0]  psize;
		int unsigned counted;
		int unsigned phase_idx;
		int unsigned target;
		int unsigned sent;
		int unsigned n;
		plan = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd2, 3'd7, 3'd1, 3'd4};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four-byte prefix after reset: two-byte payload at the byte extremes,
		// then a zero-length unit closing the frame
		frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_frame(1'b0);
		// oversized counts clamp; 0xFFFF just fits, frame ends inside the payload
		send_beat(8'h00, 17'h1FFFF);
		send_beat(8'h00, 17'h1FFFE);
		send_beat(8'hFF, 17'h1FFFD);
		send_beat(8'hFF, 17'h10000);
		send_beat(8'h80, 17'd1);
		// prefix does not fit, frame closed by a zero count
		send_beat(8'hAA, 17'd3);
		send_beat(8'h55, 17'd2);
		send_beat(8'h00, 17'd0);
		// announced length beyond the frame
		frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h33};
		send_frame(1'b0);
		// three-byte prefix size drops the frame
		settle();
		write_prefix_bytes(3'd3);
		send_beat(8'h12, 17'd2);
		send_beat(8'h34, 17'd1);

		counted   = 0;
		phase_idx = 0;
		while (counted < RANDOM_ITEMS) begin
			if (phase_idx < 8)
				psize = plan[phase_idx];
			else if ($urandom_range(0, 9) == 0)
				psize = 3'($urandom_range(3, 7));
			else
				psize = 3'd1 << $urandom_range(0, 2);
			settle();
			write_prefix_bytes(psize);
			calm = (phase_idx == 2 || phase_idx == 3);
			if (phase_idx == 1)
				hold_req = 1'b1;
			if (psize inside {3'd1, 3'd2, 3'd4}) begin
				target = $urandom_range(12, 24);
				sent   = 0;
				while (sent < target) begin
					send_random_frame(psize, n);
					sent += n;
				end
				counted += sent;
			end else begin
				send_noise(3);
			end
			phase_idx++;
		end
		calm = 1'b0;
		settle();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
